/* hdl/positional_list_insert_delete_find_top_defines.svh */
// Assertion macros for the positional list block.
`ifndef POSITIONAL_LIST_INSERT_DELETE_FIND_TOP_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_FIND_TOP_DEFINES_SVH

// Check a property on every clock edge while out of reset.
`define PLIST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PLIST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/plist_pkg.sv */
// Shared types and codes for the positional list block.
`default_nettype none

package plist_pkg;

  // Transaction opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOCATE = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_BADPOS   = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  // Cell commands broadcast to the whole row
  localparam logic [2:0] CELL_HOLD = 3'd0;
  localparam logic [2:0] CELL_INS  = 3'd1;
  localparam logic [2:0] CELL_DEL  = 3'd2;
  localparam logic [2:0] CELL_CMP  = 3'd3;
  localparam logic [2:0] CELL_SCAN = 3'd4;

  // Width of a cell's own index (row holds at most 512 cells)
  localparam int CELL_IW = 9;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  pos_idx;  // 0-based target position
    logic [31:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* hdl/positional_list_insert_delete_find_top.sv */
// Top level of the positional list: row of list cells, length counter, locate scan.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid, in_stall, in_opcode, in_position,  | into block
//           | in_value                                     |
//   out     | out_valid, out_stall, out_status,            | out of block
//           | out_found_position, out_list_length          |
//
// Insert, delete and no-op need no scan: the whole row shifts in parallel
// and the result goes straight into the output register. Locate first
// compares every cell, then the match flags walk toward cell 0 one cell per
// cycle until a match reaches cell 0 or the walk has covered the whole list.
// Reset (rst_n low, synchronous) empties the list; cell contents stay as is.
// Hold in_stall while a locate runs or a held result is stalled.
`default_nettype none

`include "positional_list_insert_delete_find_top_defines.svh"

module positional_list_insert_delete_find_top
  import plist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  in_opcode,
  input  wire logic        [4:0]  in_position,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [1:0]  out_status,
  output logic             [4:0]  out_found_position,
  output logic             [4:0]  out_list_length
);

  // Count width holds CAPACITY itself; compare width covers both count and position.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ((CW > 5) ? CW : 5) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Controller states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_k_r, scan_k_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [4:0]    out_found_r, out_found_nxt;
  logic [4:0]    out_len_r, out_len_nxt;

  logic          in_acc;
  logic          out_free;
  cell_cmd_t     cmd;
  logic [EW-1:0] cnt_e, pos_e, k_e;
  logic          pos_zero;

  logic [31:0] cell_data  [CAPACITY];
  logic        cell_match [CAPACITY];

  // Accept only while idle and with room in the output register.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;

  assign cnt_e    = EW'(count_r);
  assign pos_e    = EW'(in_position);
  assign k_e      = EW'(scan_k_r);
  assign pos_zero = (in_position == 5'd0);

  // Length as it will stand after this cycle, low five bits
  function automatic logic [4:0] len5(input logic [CW-1:0] c);
    logic [CW+4:0] ext;
    ext = {5'b0, c};
    return ext[4:0];
  endfunction

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_k_nxt     = scan_k_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_len_nxt    = out_len_r;
    // Drop the held result once it is taken.
    out_valid_nxt  = out_valid_r && out_stall;
    cmd.op         = CELL_HOLD;
    cmd.pos_idx    = in_position - 5'd1;
    cmd.value      = in_value;

    if (in_acc) begin
      out_found_nxt = 5'd0;
      out_len_nxt   = len5(count_r);
      out_status_nxt = STAT_OK;
      unique case (in_opcode)
        OP_INSERT: begin
          if (count_r >= CAP_C) begin
            out_status_nxt = STAT_FULL;
          end else if (pos_zero || (pos_e > cnt_e + EW'(1))) begin
            out_status_nxt = STAT_BADPOS;
          end else begin
            cmd.op      = CELL_INS;
            count_nxt   = count_r + CW'(1);
            out_len_nxt = len5(count_r + CW'(1));
          end
          out_valid_nxt = 1'b1;
        end
        OP_DELETE: begin
          if (pos_zero || (pos_e > cnt_e)) begin
            out_status_nxt = STAT_BADPOS;
          end else begin
            cmd.op      = CELL_DEL;
            count_nxt   = count_r - CW'(1);
            out_len_nxt = len5(count_r - CW'(1));
          end
          out_valid_nxt = 1'b1;
        end
        OP_LOCATE: begin
          // Compare every cell now, then walk the match flags.
          cmd.op     = CELL_CMP;
          scan_k_nxt = '0;
          state_nxt  = S_SCAN;
        end
        OP_NOP: begin
          out_valid_nxt = 1'b1;
        end
        default: ;
      endcase
    end else if (state_r == S_SCAN) begin
      if (scan_k_r == count_r) begin
        out_status_nxt = STAT_NOTFOUND;
        out_found_nxt  = 5'd0;
        out_len_nxt    = len5(count_r);
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end else if (cell_match[0]) begin
        out_status_nxt = STAT_OK;
        out_found_nxt  = 5'(k_e + EW'(1));
        out_len_nxt    = len5(count_r);
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end else begin
        // Advance the flags one cell toward the head.
        cmd.op     = CELL_SCAN;
        scan_k_nxt = scan_k_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_k_r     <= scan_k_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_len_r    <= out_len_nxt;
  end

  // Row of list cells; cell i holds 1-based position i+1.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left_d, right_d;
    logic        right_m;

    if (i == 0) begin : g_head
      assign left_d = in_value;
    end else begin : g_body
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
      assign right_m = 1'b0;
    end else begin : g_inner
      assign right_d = cell_data[i+1];
      assign right_m = cell_match[i+1];
    end

    plist_cell #(
      .IDX(i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .right_match(right_m),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_list_length    = out_len_r;

  // The list never grows past its capacity.
  `PLIST_ASSERT(a_count_bound, (count_r <= CAP_C), "list length above capacity")
  // While a locate walks the row the output register stays empty.
  `PLIST_ASSERT(a_scan_out_empty, (state_r == S_SCAN) |-> !out_valid_r, "result held during scan")
  // The scan never walks past the end of the list.
  `PLIST_ASSERT_ALWAYS(a_scan_k, rst_n && state_r == S_SCAN |-> scan_k_r <= count_r, "scan overrun")

endmodule

`default_nettype wire

/* hdl/plist_cell.sv */
// One list cell: holds an entry and its match flag, trades data with neighbors.
`default_nettype none

module plist_cell
  import plist_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic        clk,
  input  wire cell_cmd_t   cmd,
  input  wire logic [31:0] left_data,
  input  wire logic [31:0] right_data,
  input  wire logic        right_match,
  output logic      [31:0] data,
  output logic             match
);

  localparam logic [CELL_IW-1:0] MY_IDX = CELL_IW'(IDX);

  logic [31:0]        data_r, data_nxt;
  logic               match_r, match_nxt;
  logic [CELL_IW-1:0] tgt;

  assign tgt = {{(CELL_IW-5){1'b0}}, cmd.pos_idx};

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    unique case (cmd.op)
      CELL_INS: begin
        if (MY_IDX == tgt) begin
          data_nxt = cmd.value;
        end else if (MY_IDX > tgt) begin
          data_nxt = left_data;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= tgt) begin
          data_nxt = right_data;
        end
      end
      CELL_CMP:  match_nxt = (data_r == cmd.value);
      CELL_SCAN: match_nxt = right_match;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

`default_nettype wire

/* tb/plist_tb_pkg.sv */
// Scoreboard for the positional list testbench: list predictor and result checker.
package plist_tb_pkg;
  import plist_pkg::*;

  localparam int LIST_CAP = 16;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] found_pos;
    logic [4:0] length;
  } list_result_t;

  class plist_scoreboard;
    logic signed [31:0] shadow_entries [LIST_CAP];
    int unsigned        length;
    list_result_t       pending_results [$];
    int unsigned        mismatches;
    int unsigned        results_checked;
    int unsigned        status_seen [4];

    function new();
      length          = 0;
      mismatches      = 0;
      results_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Apply one accepted transaction to the shadow list and queue its result.
    function void note_transaction(logic [1:0] op, logic [4:0] pos, logic signed [31:0] val);
      list_result_t res;
      int           k;
      int           p;
      bit           hit;
      res.status    = STAT_OK;
      res.found_pos = '0;
      hit           = 1'b0;
      p             = int'(pos);
      case (op)
        OP_INSERT: begin
          if (length >= LIST_CAP) begin
            res.status = STAT_FULL;
          end else if (p < 1 || p > int'(length) + 1) begin
            res.status = STAT_BADPOS;
          end else begin
            for (k = int'(length); k >= p; k--) shadow_entries[k] = shadow_entries[k - 1];
            shadow_entries[p - 1] = val;
            length++;
          end
        end
        OP_DELETE: begin
          if (p < 1 || p > int'(length)) begin
            res.status = STAT_BADPOS;
          end else begin
            for (k = p - 1; k + 1 < int'(length); k++) shadow_entries[k] = shadow_entries[k + 1];
            length--;
          end
        end
        OP_LOCATE: begin
          res.status = STAT_NOTFOUND;
          for (k = 0; k < int'(length); k++) begin
            if (!hit && shadow_entries[k] == val) begin
              hit           = 1'b1;
              res.status    = STAT_OK;
              res.found_pos = 5'(k + 1);
            end
          end
        end
        default: begin
        end
      endcase
      res.length = 5'(length);
      status_seen[res.status]++;
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [1:0] st, logic [4:0] fp, logic [4:0] ln);
      list_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d found %0d length %0d", st, fp, ln);
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (st !== want.status || fp !== want.found_pos || ln !== want.length) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: expected status %0d found %0d length %0d, got %0d %0d %0d",
                   results_checked, want.status, want.found_pos, want.length, st, fp, ln);
      end
    endfunction
  endclass

endpackage

/* tb/tb_positional_list_insert_delete_find_top.sv */
// Testbench top for the positional list: directed and random list traffic with a scoreboard.
module tb_positional_list_insert_delete_find_top;
  import plist_pkg::*;
  import plist_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1080;
  localparam int QUIET_ITEMS  = 150;     // tail of the run with no idling on either side
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24;      // quiet time to watch for stray results

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_NOISE} traffic_mode_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic        [1:0]  in_opcode   = OP_NOP;
  logic        [4:0]  in_position = '0;
  logic signed [31:0] in_value    = '0;
  logic               out_stall   = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic        [1:0]  out_status;
  logic        [4:0]  out_found_position;
  logic        [4:0]  out_list_length;

  plist_scoreboard list_check = new();

  int unsigned cycles     = 0;
  int unsigned op_sent [4] = '{0, 0, 0, 0};
  bit          stall_enable = 1'b0;
  int          stall_left   = 0;

  positional_list_insert_delete_find_top #(.CAPACITY(LIST_CAP)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a correct run finishes far below this many cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: stall in random bursts while enabled.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (stall_enable && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 6);
    end
  end

  // Check every result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      list_check.check_result(out_status, out_found_position, out_list_length);
  end

  // Present one transaction and hold it until the block takes it, then predict.
  task automatic send_item(input logic [1:0] op, input logic [4:0] pos,
                           input logic signed [31:0] val);
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    list_check.note_transaction(op, pos, val);
    op_sent[op]++;
  endtask

  task automatic hold_off(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (list_check.pending() != 0) @(posedge clk);
  endtask

  // Mostly a small pool so that locates hit and duplicates occur; rest fully random.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    if ($urandom_range(0, 9) < 4) return $urandom;
    case ($urandom_range(0, 7))
      0:       v = VAL_MIN;
      1:       v = VAL_MAX;
      2:       v = 32'sd0;
      3:       v = -32'sd1;
      4:       v = 32'sd1;
      5:       v = 32'sd7;
      6:       v = 32'sh1234_5678;
      default: v = 32'sh8000_0001;
    endcase
    return v;
  endfunction

  function automatic void make_item(input traffic_mode_t mode, output logic [1:0] op,
                                    output logic [4:0] pos, output logic signed [31:0] val);
    int unsigned len;
    int unsigned r;
    len = list_check.length;
    r   = $urandom_range(0, 99);
    if (mode == MODE_NOISE) begin
      op  = 2'($urandom_range(0, 3));
      pos = 5'($urandom_range(0, 31));
      val = $urandom;
      return;
    end
    case (mode)
      MODE_GROW:   op = (r < 70) ? OP_INSERT : (r < 90) ? OP_LOCATE : OP_DELETE;
      MODE_SHRINK: op = (r < 65) ? OP_DELETE : (r < 85) ? OP_LOCATE : OP_INSERT;
      default:     op = (r < 35) ? OP_INSERT : (r < 70) ? OP_DELETE : OP_LOCATE;
    endcase
    val = pick_value();
    pos = 5'($urandom_range(0, 31));
    // Well-formed positions most of the time, out-of-range ones now and then.
    if ($urandom_range(0, 9) != 0) begin
      if (op == OP_INSERT) pos = 5'($urandom_range(1, len + 1));
      else if (op == OP_DELETE && len > 0) pos = 5'($urandom_range(1, len));
    end
    if (op == OP_LOCATE && len > 0 && $urandom_range(0, 1) == 0)
      val = list_check.shadow_entries[$urandom_range(0, len - 1)];
  endfunction

  initial begin
    traffic_mode_t      mode;
    logic        [1:0]  op;
    logic        [4:0]  pos;
    logic signed [31:0] val;
    int                 sent_random;
    int                 seg_len;
    int                 seg_count;
    int                 r;
    bit                 seg_idle;
    bit                 quiet;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list errors, bad positions, extremes, front/middle/end insert,
    // duplicate locate, delete first and last, and a no-op with odd fields.
    send_item(OP_LOCATE, 5'd0,  32'sd0);
    send_item(OP_DELETE, 5'd1,  32'sd0);
    send_item(OP_INSERT, 5'd0,  32'sd5);
    send_item(OP_INSERT, 5'd2,  32'sd5);
    send_item(OP_INSERT, 5'd1,  VAL_MIN);
    send_item(OP_INSERT, 5'd2,  VAL_MAX);
    send_item(OP_INSERT, 5'd1,  32'sd0);
    send_item(OP_INSERT, 5'd3,  -32'sd1);
    send_item(OP_INSERT, 5'd1,  VAL_MAX);
    send_item(OP_LOCATE, 5'd31, VAL_MAX);
    send_item(OP_LOCATE, 5'd0,  -32'sd1);
    send_item(OP_LOCATE, 5'd3,  32'sh5a5a_a5a5);
    send_item(OP_DELETE, 5'd0,  32'sd0);
    send_item(OP_DELETE, 5'd6,  32'sd0);
    send_item(OP_DELETE, 5'd31, -32'sd1);
    send_item(OP_INSERT, 5'd31, 32'sd9);
    send_item(OP_INSERT, 5'd6,  32'sd1);
    send_item(OP_NOP,    5'd31, -32'sd1);
    send_item(OP_DELETE, 5'd6,  32'sd0);
    send_item(OP_DELETE, 5'd1,  32'sd0);
    send_item(OP_LOCATE, 5'd16, VAL_MAX);

    // Hold the sender until the directed results are all back.
    wait_for_results();

    // Random traffic in segments; the first one grows the list.
    sent_random = 0;
    seg_count   = 0;
    while (sent_random < RANDOM_ITEMS) begin
      seg_len = $urandom_range(30, 80);
      r       = $urandom_range(0, 99);
      if (seg_count == 0) mode = MODE_GROW;
      else mode = (r < 30) ? MODE_GROW : (r < 55) ? MODE_SHRINK :
                  (r < 85) ? MODE_MIXED : MODE_NOISE;
      seg_idle = ($urandom_range(0, 3) != 0);
      if (seg_count % 4 == 3) wait_for_results();
      for (int i = 0; i < seg_len && sent_random < RANDOM_ITEMS; i++) begin
        quiet        = (sent_random >= RANDOM_ITEMS - QUIET_ITEMS);
        stall_enable <= seg_idle && !quiet;
        if (seg_idle && !quiet && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 6));
        make_item(mode, op, pos, val);
        send_item(op, pos, val);
        sent_random++;
      end
      seg_count++;
    end

    // Let the last results come back, then watch for stray ones.
    stall_enable <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions: %0d insert, %0d delete, %0d locate, %0d no-op.",
             op_sent[0] + op_sent[1] + op_sent[2] + op_sent[3],
             op_sent[OP_INSERT], op_sent[OP_DELETE], op_sent[OP_LOCATE], op_sent[OP_NOP]);
    $display("Checked %0d results: ok %0d, full %0d, bad position %0d, no match %0d.",
             list_check.results_checked, list_check.status_seen[STAT_OK],
             list_check.status_seen[STAT_FULL], list_check.status_seen[STAT_BADPOS],
             list_check.status_seen[STAT_NOTFOUND]);
    if (list_check.mismatches != 0 || list_check.pending() != 0) begin
      $display("Some tests failed");
    end else begin
      $display("All tests passed");
    end
    $finish;
  end

endmodule

/* positional_list_insert_delete_find_top.f */
+incdir+hdl
hdl/plist_pkg.sv
hdl/plist_cell.sv
hdl/positional_list_insert_delete_find_top.sv
tb/plist_tb_pkg.sv
tb/tb_positional_list_insert_delete_find_top.sv
